// ===== hw/rtl/gcrfi_pkg.sv =====
// shared types, constants and the divider step for the grid cell rectangle block
package gcrfi_pkg;

    // field widths
    localparam int IDX_W   = 16;
    localparam int SIZE_W  = 12;
    localparam int GAP_W   = 10;
    localparam int PAD_W   = 12;
    localparam int CNT_W   = 13;
    localparam int EDGE_W  = 32;
    localparam int LIMIT_W = 25;
    localparam int STEP_W  = 13;
    localparam int PROD_W  = IDX_W + STEP_W;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 160;
    localparam int CFG_W   = 12;
    localparam int ADDR_W  = 3;

    // configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_COLUMN_SPACING    = 3'd0,
        REG_ROW_SPACING       = 3'd1,
        REG_PAD_LEFT          = 3'd2,
        REG_PAD_TOP           = 3'd3,
        REG_PAD_RIGHT         = 3'd4,
        REG_PAD_BOTTOM        = 3'd5,
        REG_PRIMARY_DIRECTION = 3'd6,
        REG_START_CORNER      = 3'd7
    } reg_index_t;

    // start corner bits
    localparam int CORNER_RIGHT_BIT  = 0;
    localparam int CORNER_BOTTOM_BIT = 1;

    // item fields that ride along the pipeline
    typedef struct packed {
        logic [IDX_W-1:0]  item_index;
        logic [SIZE_W-1:0] item_width;
        logic [SIZE_W-1:0] item_height;
        logic [SIZE_W-1:0] container_width;
        logic [SIZE_W-1:0] container_height;
    } side_t;

    // one lane of a restoring divider: numerator shifts out, quotient shifts in
    typedef struct packed {
        logic [IDX_W-1:0] nq;
        logic [CNT_W-1:0] rem;
        logic [CNT_W-1:0] den;
    } lane_t;

    // one quotient bit per call
    function automatic lane_t div_step(lane_t a);
        lane_t           b;
        logic [CNT_W:0]  t;
        logic [CNT_W:0]  d;
        b = a;
        t = {a.rem, a.nq[IDX_W-1]};
        d = {1'b0, a.den};
        if (t >= d) begin
            b.rem = CNT_W'(t - d);
            b.nq  = {a.nq[IDX_W-2:0], 1'b1};
        end else begin
            b.rem = t[CNT_W-1:0];
            b.nq  = {a.nq[IDX_W-2:0], 1'b0};
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/grid_cell_rect_from_index.sv =====
// Grid cell rectangle from item index: fit counts, index split, edge placement.
// Takes one item per cycle unless the output is held; the pipeline depth
// comes from two 16-stage restoring dividers in series (one for the fit counts
// per row and per column, one for splitting the index into row and column),
// followed by a multiply stage and an edge-add stage. The whole pipeline holds
// while a finished result is not taken. Configuration is read live, so the user
// must write it only while no transfer is in flight; the block does not enforce this.
module grid_cell_rect_from_index (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [gcrfi_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [gcrfi_pkg::CFG_W-1:0]   cfg_wdata,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // item_index, item_width, item_height, container_width, container_height
    input  logic [gcrfi_pkg::IN_W-1:0]    s_tdata,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // rect_left, rect_top, rect_right, rect_bottom, item_limit, zero fill
    output logic [gcrfi_pkg::OUT_W-1:0]   m_tdata
);

    localparam int DIV_STEPS = gcrfi_pkg::IDX_W;
    localparam int LAST_ST   = 2 * DIV_STEPS + 2;

    // configuration registers
    logic [gcrfi_pkg::GAP_W-1:0] col_gap_reg;
    logic [gcrfi_pkg::GAP_W-1:0] row_gap_reg;
    logic [gcrfi_pkg::PAD_W-1:0] pad_left_reg;
    logic [gcrfi_pkg::PAD_W-1:0] pad_top_reg;
    logic [gcrfi_pkg::PAD_W-1:0] pad_right_reg;
    logic [gcrfi_pkg::PAD_W-1:0] pad_bottom_reg;
    logic                        dir_reg;
    logic [1:0]                  corner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_gap_reg    <= gcrfi_pkg::GAP_W'(2);
            row_gap_reg    <= gcrfi_pkg::GAP_W'(2);
            pad_left_reg   <= '0;
            pad_top_reg    <= '0;
            pad_right_reg  <= '0;
            pad_bottom_reg <= '0;
            dir_reg        <= 1'b0;
            corner_reg     <= 2'd0;
        end else if (cfg_wr_en) begin
            case (gcrfi_pkg::reg_index_t'(cfg_addr))
                gcrfi_pkg::REG_COLUMN_SPACING:    col_gap_reg    <= cfg_wdata[gcrfi_pkg::GAP_W-1:0];
                gcrfi_pkg::REG_ROW_SPACING:       row_gap_reg    <= cfg_wdata[gcrfi_pkg::GAP_W-1:0];
                gcrfi_pkg::REG_PAD_LEFT:          pad_left_reg   <= cfg_wdata;
                gcrfi_pkg::REG_PAD_TOP:           pad_top_reg    <= cfg_wdata;
                gcrfi_pkg::REG_PAD_RIGHT:         pad_right_reg  <= cfg_wdata;
                gcrfi_pkg::REG_PAD_BOTTOM:        pad_bottom_reg <= cfg_wdata;
                gcrfi_pkg::REG_PRIMARY_DIRECTION: dir_reg        <= cfg_wdata[0];
                gcrfi_pkg::REG_START_CORNER:      corner_reg     <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipeline moves unless the output is held
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    // valid bits and side fields, stage 0 .. LAST_ST
    logic                v_reg  [0:LAST_ST];
    gcrfi_pkg::side_t    sd_reg [0:LAST_ST];

    // first divider lanes (fit counts)
    gcrfi_pkg::lane_t    l1x_reg   [0:DIV_STEPS];
    gcrfi_pkg::lane_t    l1y_reg   [0:DIV_STEPS];
    logic                one_x_reg [0:DIV_STEPS];
    logic                one_y_reg [0:DIV_STEPS];

    // second divider lane (index split) with the counts riding along
    gcrfi_pkg::lane_t               l2_reg  [0:DIV_STEPS];
    logic [gcrfi_pkg::CNT_W-1:0]    prow_reg [0:DIV_STEPS];
    logic [gcrfi_pkg::CNT_W-1:0]    pcol_reg [0:DIV_STEPS];

    // stage 0: unpack, numerators and divisors
    gcrfi_pkg::side_t            in_side;
    logic signed [14:0]          num_x;
    logic signed [14:0]          num_y;
    logic [gcrfi_pkg::CNT_W-1:0] den_x;
    logic [gcrfi_pkg::CNT_W-1:0] den_y;

    always_comb begin
        in_side.item_index       = s_tdata[15:0];
        in_side.item_width       = s_tdata[27:16];
        in_side.item_height      = s_tdata[39:28];
        in_side.container_width  = s_tdata[51:40];
        in_side.container_height = s_tdata[63:52];
        num_x = $signed({3'b0, in_side.container_width}) - $signed({3'b0, pad_left_reg})
              - $signed({3'b0, pad_right_reg}) + $signed({5'b0, col_gap_reg});
        num_y = $signed({3'b0, in_side.container_height}) - $signed({3'b0, pad_top_reg})
              - $signed({3'b0, pad_bottom_reg}) + $signed({5'b0, row_gap_reg});
        den_x = {1'b0, in_side.item_width} + {3'b0, col_gap_reg};
        den_y = {1'b0, in_side.item_height} + {3'b0, row_gap_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0]      <= in_side;
            l1x_reg[0].nq  <= {3'b0, num_x[12:0]};
            l1x_reg[0].rem <= '0;
            l1x_reg[0].den <= den_x;
            l1y_reg[0].nq  <= {3'b0, num_y[12:0]};
            l1y_reg[0].rem <= '0;
            l1y_reg[0].den <= den_y;
            // nonpositive space or zero divisor gives a count of one
            one_x_reg[0]   <= (num_x <= 15'sd0) || (den_x == '0);
            one_y_reg[0]   <= (num_y <= 15'sd0) || (den_y == '0);
        end
    end

    // valid and side fields shift through every stage
    for (genvar k = 1; k <= LAST_ST; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // first divider: one quotient bit per stage
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div1
        always_ff @(posedge aclk) begin
            if (en) begin
                l1x_reg[k]   <= gcrfi_pkg::div_step(l1x_reg[k-1]);
                l1y_reg[k]   <= gcrfi_pkg::div_step(l1y_reg[k-1]);
                one_x_reg[k] <= one_x_reg[k-1];
                one_y_reg[k] <= one_y_reg[k-1];
            end
        end
    end

    // clamp counts and load the index divider
    logic [gcrfi_pkg::CNT_W-1:0] per_row;
    logic [gcrfi_pkg::CNT_W-1:0] per_col;

    always_comb begin
        per_row = l1x_reg[DIV_STEPS].nq[gcrfi_pkg::CNT_W-1:0];
        per_col = l1y_reg[DIV_STEPS].nq[gcrfi_pkg::CNT_W-1:0];
        if (one_x_reg[DIV_STEPS] || per_row == '0) begin
            per_row = gcrfi_pkg::CNT_W'(1);
        end
        if (one_y_reg[DIV_STEPS] || per_col == '0) begin
            per_col = gcrfi_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l2_reg[0].nq  <= sd_reg[DIV_STEPS].item_index;
            l2_reg[0].rem <= '0;
            l2_reg[0].den <= dir_reg ? per_col : per_row;
            prow_reg[0]   <= per_row;
            pcol_reg[0]   <= per_col;
        end
    end

    // second divider: index over the count along the fill direction
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div2
        always_ff @(posedge aclk) begin
            if (en) begin
                l2_reg[k]   <= gcrfi_pkg::div_step(l2_reg[k-1]);
                prow_reg[k] <= prow_reg[k-1];
                pcol_reg[k] <= pcol_reg[k-1];
            end
        end
    end

    // multiply stage: offsets along each axis and the item limit
    logic [gcrfi_pkg::IDX_W-1:0]   row_num;
    logic [gcrfi_pkg::IDX_W-1:0]   col_num;
    logic [gcrfi_pkg::STEP_W-1:0]  step_x;
    logic [gcrfi_pkg::STEP_W-1:0]  step_y;
    logic [gcrfi_pkg::PROD_W-1:0]  px_reg;
    logic [gcrfi_pkg::PROD_W-1:0]  py_reg;
    logic [gcrfi_pkg::LIMIT_W-1:0] limit_reg;
    logic [2*gcrfi_pkg::CNT_W-1:0] limit_full;

    always_comb begin
        if (dir_reg) begin
            col_num = l2_reg[DIV_STEPS].nq;
            row_num = {3'b0, l2_reg[DIV_STEPS].rem};
        end else begin
            row_num = l2_reg[DIV_STEPS].nq;
            col_num = {3'b0, l2_reg[DIV_STEPS].rem};
        end
        step_x     = {1'b0, sd_reg[2*DIV_STEPS+1].item_width} + {3'b0, col_gap_reg};
        step_y     = {1'b0, sd_reg[2*DIV_STEPS+1].item_height} + {3'b0, row_gap_reg};
        limit_full = prow_reg[DIV_STEPS] * pcol_reg[DIV_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg    <= col_num * step_x;
            py_reg    <= row_num * step_y;
            limit_reg <= limit_full[gcrfi_pkg::LIMIT_W-1:0];
        end
    end

    // edge stage: place from the start corner
    gcrfi_pkg::side_t             ms;
    logic [gcrfi_pkg::EDGE_W-1:0] left_n;
    logic [gcrfi_pkg::EDGE_W-1:0] top_n;
    logic [gcrfi_pkg::EDGE_W-1:0] right_n;
    logic [gcrfi_pkg::EDGE_W-1:0] bottom_n;
    logic [gcrfi_pkg::OUT_W-1:0]  m_tdata_reg;

    always_comb begin
        ms = sd_reg[LAST_ST];
        if (corner_reg[gcrfi_pkg::CORNER_RIGHT_BIT]) begin
            right_n = {20'b0, ms.container_width} - {20'b0, pad_right_reg} - {3'b0, px_reg};
            left_n  = right_n - {20'b0, ms.item_width};
        end else begin
            left_n  = {20'b0, pad_left_reg} + {3'b0, px_reg};
            right_n = left_n + {20'b0, ms.item_width};
        end
        if (corner_reg[gcrfi_pkg::CORNER_BOTTOM_BIT]) begin
            bottom_n = {20'b0, ms.container_height} - {20'b0, pad_bottom_reg} - {3'b0, py_reg};
            top_n    = bottom_n - {20'b0, ms.item_height};
        end else begin
            top_n    = {20'b0, pad_top_reg} + {3'b0, py_reg};
            bottom_n = top_n + {20'b0, ms.item_height};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v_reg[LAST_ST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {7'b0, limit_reg, bottom_n, right_n, top_n, left_n};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule
